/* hw/rtl/kvte_pkg.sv */
// Package for the key-value table engine: operation codes, sequencer states,
// the stored entry type and default sizing. No dependencies.
package kvte_pkg;

   localparam int KVTE_CAPACITY = 32;
   localparam int KEY_W         = 8;
   localparam int VALUE_W       = 16;
   localparam int USED_W        = 6;

   typedef enum logic [2:0] {
      KIND_INSERT   = 3'd0,
      KIND_DELETE   = 3'd1,
      KIND_REASSIGN = 3'd2,
      KIND_LOOKUP   = 3'd3,
      KIND_CLEAR    = 3'd4
   } kvte_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_ACT,
      ST_SHIFT,
      ST_DONE
   } kvte_state_type;

   typedef struct packed {
      logic [KEY_W-1:0]          key;
      logic signed [VALUE_W-1:0] value;
   } kvte_entry_type;

endpackage

/* hw/rtl/kvte_if.sv */
// Channel interfaces for the key-value table engine: request and response
// beats with valid/ready. Depends on kvte_pkg for field widths.
interface kvte_req_if
   import kvte_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic [2:0]                kind;
   logic [KEY_W-1:0]          key;
   logic signed [VALUE_W-1:0] new_value;

   modport source (output valid, output kind, output key, output new_value, input ready);
   modport sink   (input valid, input kind, input key, input new_value, output ready);
endinterface

interface kvte_rsp_if
   import kvte_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic                      hit;
   logic signed [VALUE_W-1:0] read_value;
   logic [USED_W-1:0]         entries_used;
   logic                      table_full_error;

   modport source (output valid, output hit, output read_value, output entries_used,
                   output table_full_error, input ready);
   modport sink   (input valid, input hit, input read_value, input entries_used,
                   input table_full_error, output ready);
endinterface

/* hw/rtl/kvte_store.sv */
// Entry memory of the key-value table: one write port, one read port with
// registered read data. Depends on kvte_pkg for the entry type.
module kvte_store
   import kvte_pkg::*;
#(
   parameter int DEPTH = KVTE_CAPACITY,
   localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic           clock,
   input  logic           wr_en,
   input  logic [IW-1:0]  wr_addr,
   input  kvte_entry_type wr_data,
   input  logic [IW-1:0]  rd_addr,
   output kvte_entry_type rd_data
);

   kvte_entry_type mem [DEPTH];
   kvte_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/key_value_table_engine_core.sv */
// Top level of the key-value table engine: sequencer, key compare and
// shift logic around the entry memory. Depends on kvte_pkg, kvte_if, kvte_store.
//
//   channel   | dir | beat contents
//   ----------+-----+----------------------------------------------
//   req_chan  | in  | kind, key, new_value
//   rsp_chan  | out | hit, read_value, entries_used, table_full_error
//
// The time a request takes grows with N, the entry count when it is taken:
// the search reads one entry per cycle from the single read port of the entry
// memory, and a delete then moves one entry per cycle down to close the gap.
// Reset clears only the entry count and control; no memory clearing pass.
// A response waits in its output register; a stalled response holds the
// sequencer in its final state until the beat is taken.
module key_value_table_engine_core
   import kvte_pkg::*;
#(
   parameter int CAPACITY = KVTE_CAPACITY
) (
   input  logic       clock,
   input  logic       reset,
   kvte_req_if.sink   req_chan,
   kvte_rsp_if.source rsp_chan
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = CW + 1;

   kvte_state_type            state_ff, state_in;
   kvte_kind_type             kind_ff, kind_in;
   logic [KEY_W-1:0]          key_ff, key_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic [IW-1:0]             idx_ff, idx_in;
   logic [CW-1:0]             count_ff, count_in;
   logic                      hit_ff, hit_in;
   logic signed [VALUE_W-1:0] rd_ff, rd_in;
   logic                      err_ff, err_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_hit_ff, rsp_hit_in;
   logic signed [VALUE_W-1:0] rsp_val_ff, rsp_val_in;
   logic [USED_W-1:0]         rsp_cnt_ff, rsp_cnt_in;
   logic                      rsp_err_ff, rsp_err_in;

   logic                      wr_en;
   logic [IW-1:0]             wr_addr;
   kvte_entry_type            wr_data;
   logic [IW-1:0]             rd_addr;
   kvte_entry_type            rd_data;

   logic [XW-1:0]             idx_p1;
   logic [XW-1:0]             idx_p2;
   logic [XW-1:0]             count_x;
   logic                      rsp_free;

   kvte_store #(.DEPTH(CAPACITY)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign idx_p1   = XW'(idx_ff) + XW'(1);
   assign idx_p2   = XW'(idx_ff) + XW'(2);
   assign count_x  = XW'(count_ff);
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      key_ff     <= key_in;
      val_ff     <= val_in;
      idx_ff     <= idx_in;
      hit_ff     <= hit_in;
      rd_ff      <= rd_in;
      err_ff     <= err_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_val_ff <= rsp_val_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_err_ff <= rsp_err_in;
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      hit_in       = hit_ff;
      rd_in        = rd_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_err_in   = rsp_err_ff;
      req_chan.ready = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = '{key: key_ff, value: val_ff};
      rd_addr      = IW'(idx_p1);

      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            rd_addr        = '0;
            if (req_chan.valid) begin
               kind_in  = kvte_kind_type'(req_chan.kind);
               key_in   = req_chan.key;
               val_in   = req_chan.new_value;
               idx_in   = '0;
               hit_in   = 1'b0;
               rd_in    = '0;
               err_in   = 1'b0;
               state_in = (count_ff == '0) ? ST_ACT : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // read data holds entry idx_ff; next address already on the port
            if (rd_data.key == key_ff) begin
               hit_in   = 1'b1;
               rd_in    = rd_data.value;
               state_in = ST_ACT;
            end else if (idx_p1 == count_x) begin
               state_in = ST_ACT;
            end else begin
               idx_in = IW'(idx_p1);
            end
         end
         ST_ACT: begin
            state_in = ST_DONE;
            if (kind_ff != KIND_LOOKUP) begin
               rd_in = '0;
            end
            case (kind_ff)
               KIND_INSERT: begin
                  if (hit_ff) begin
                     wr_en = 1'b1;
                  end else if (count_x < XW'(CAPACITY)) begin
                     wr_en    = 1'b1;
                     wr_addr  = IW'(count_ff);
                     count_in = count_ff + CW'(1);
                  end else begin
                     err_in = 1'b1;
                  end
               end
               KIND_REASSIGN: begin
                  wr_en = hit_ff;
               end
               KIND_DELETE: begin
                  if (hit_ff) begin
                     if (idx_p1 < count_x) begin
                        rd_addr  = IW'(idx_p1);
                        state_in = ST_SHIFT;
                     end else begin
                        count_in = count_ff - CW'(1);
                     end
                  end
               end
               KIND_CLEAR: begin
                  count_in = '0;
               end
               default: begin
               end
            endcase
         end
         ST_SHIFT: begin
            // move entry idx_ff+1 down one place
            wr_en   = 1'b1;
            wr_data = rd_data;
            idx_in  = IW'(idx_p1);
            if (idx_p2 < count_x) begin
               rd_addr = IW'(idx_p2);
            end else begin
               count_in = count_ff - CW'(1);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               rsp_val_in   = rd_ff;
               rsp_cnt_in   = USED_W'(count_ff);
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.hit              = rsp_hit_ff;
   assign rsp_chan.read_value       = rsp_val_ff;
   assign rsp_chan.entries_used     = rsp_cnt_ff;
   assign rsp_chan.table_full_error = rsp_err_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> XW'(wr_addr) <= count_x)
      else $error("write beyond packed entries");

   a_full_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.table_full_error |-> !rsp_chan.hit)
      else $error("full error with hit");

   a_value_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.read_value != '0) |-> rsp_chan.hit)
      else $error("read value without hit");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |=> $stable(count_ff))
      else $error("count changed during search");
`endif

endmodule

/* dv/key_value_table_engine_core_tb.sv */
// Testbench for key_value_table_engine_core: random request beats against a
// scoreboard that mirrors the table. Depends on kvte_pkg and kvte_if.
module key_value_table_engine_core_tb;
   import kvte_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = KVTE_CAPACITY;
   localparam int ITEM_TARGET = 1150;
   localparam int DRAIN_POINT_A = 24;
   localparam int DRAIN_POINT_B = 700;
   localparam int HOLD_AT = 300;
   localparam int LONG_HOLD = 400;
   localparam int TAIL_CYCLES = 2 * TABLE_DEPTH + 16;

   localparam logic [2:0] KIND_SPARE_A = 3'd5;
   localparam logic [2:0] KIND_SPARE_B = 3'd6;
   localparam logic [2:0] KIND_SPARE_C = 3'd7;

   typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_type;

   typedef struct {
      logic [2:0]                kind;
      logic [KEY_W-1:0]          key;
      logic signed [VALUE_W-1:0] new_value;
      bit                        drain;
   } table_op_type;

   typedef struct {
      logic                      hit;
      logic signed [VALUE_W-1:0] read_value;
      logic [USED_W-1:0]         entries_used;
      logic                      table_full_error;
   } table_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   kvte_req_if req_bus ();
   kvte_rsp_if rsp_bus ();

   key_value_table_engine_core #(.CAPACITY(TABLE_DEPTH)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   table_op_type     pending_ops[$];
   table_result_type expected_q[$];

   logic [KEY_W-1:0]          shadow_keys   [TABLE_DEPTH];
   logic signed [VALUE_W-1:0] shadow_values [TABLE_DEPTH];
   int shadow_count = 0;
   int peak_count = 0;
   int full_drops = 0;
   int lookup_hits = 0;
   int delete_hits = 0;

   int ops_accepted = 0;
   int rsp_count = 0;
   int mismatches = 0;

   function automatic table_result_type apply_table_op(table_op_type op);
      table_result_type res;
      int slot;
      slot = -1;
      for (int i = 0; i < shadow_count; i++)
         if (slot < 0 && shadow_keys[i] == op.key) slot = i;
      res.hit = (slot >= 0);
      res.read_value = '0;
      res.table_full_error = 1'b0;
      case (op.kind)
         KIND_INSERT: begin
            if (slot >= 0) begin
               shadow_values[slot] = op.new_value;
            end else if (shadow_count < TABLE_DEPTH) begin
               shadow_keys[shadow_count] = op.key;
               shadow_values[shadow_count] = op.new_value;
               shadow_count++;
            end else begin
               res.table_full_error = 1'b1;
               full_drops++;
            end
         end
         KIND_DELETE: begin
            if (slot >= 0) begin
               for (int j = slot; j < shadow_count - 1; j++) begin
                  shadow_keys[j] = shadow_keys[j + 1];
                  shadow_values[j] = shadow_values[j + 1];
               end
               shadow_count--;
               delete_hits++;
            end
         end
         KIND_REASSIGN: begin
            if (slot >= 0) shadow_values[slot] = op.new_value;
         end
         KIND_LOOKUP: begin
            if (slot >= 0) begin
               res.read_value = shadow_values[slot];
               lookup_hits++;
            end
         end
         KIND_CLEAR: shadow_count = 0;
         default: ;
      endcase
      res.entries_used = shadow_count[USED_W-1:0];
      if (shadow_count > peak_count) peak_count = shadow_count;
      return res;
   endfunction

   function automatic void check_field(string field, logic signed [31:0] want,
                                       logic signed [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endfunction

   task automatic queue_op(logic [2:0] kind, logic [KEY_W-1:0] key,
                           logic signed [VALUE_W-1:0] value);
      table_op_type op;
      op.kind = kind;
      op.key = key;
      op.new_value = value;
      op.drain = (pending_ops.size() == DRAIN_POINT_A || pending_ops.size() == DRAIN_POINT_B);
      pending_ops.push_back(op);
   endtask

   function automatic logic [2:0] pick_churn_kind();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return KIND_INSERT;
      if (roll < 58) return KIND_DELETE;
      if (roll < 70) return KIND_REASSIGN;
      if (roll < 94) return KIND_LOOKUP;
      if (roll < 96) return KIND_CLEAR;
      return 3'($urandom_range(KIND_SPARE_A, KIND_SPARE_C));
   endfunction

   // request driver: bursts and gaps, valid held until the beat is taken
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin : request_driver
      table_op_type head;
      bit fire;
      fire = req_bus.valid && req_bus.ready;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (fire) begin
            expected_q.push_back(apply_table_op(pending_ops.pop_front()));
            ops_accepted <= ops_accepted + 1;
         end
         if (!req_bus.valid || fire) begin
            if (pending_ops.size() == 0) begin
               req_bus.valid <= 1'b0;
            end else if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_bus.valid <= 1'b0;
            end else if (pending_ops[0].drain && (ops_accepted + fire) != rsp_count) begin
               req_bus.valid <= 1'b0;
            end else begin
               head = pending_ops[0];
               req_bus.valid <= 1'b1;
               req_bus.kind <= head.kind;
               req_bus.key <= head.key;
               req_bus.new_value <= head.new_value;
               if (burst_left <= 1) begin
                  burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                           : $urandom_range(1, 16);
                  gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
      end
   end

   // response sink: rotating stall patterns plus one long hold-off
   rx_mode_type rx_mode = RX_ALWAYS;
   int phase_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int rx_tick = 0;

   always @(posedge clock) begin : response_receiver
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rx_tick <= rx_tick + 1;
         if (phase_left == 0) begin
            rx_mode <= rx_mode_type'($urandom_range(RX_ALWAYS, RX_MOSTLY));
            phase_left <= $urandom_range(32, 256);
         end else begin
            phase_left <= phase_left - 1;
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
         end else if (!hold_done && rsp_count >= HOLD_AT) begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_ALWAYS: rsp_bus.ready <= 1'b1;
               RX_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_bus.ready <= (rx_tick % 8 == 0);
               default:   rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : response_monitor
      table_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_count <= rsp_count + 1;
         if (expected_q.size() == 0) begin
            $error("response beat with no request outstanding");
            mismatches++;
         end else begin
            want = expected_q.pop_front();
            check_field("hit", 32'(want.hit), 32'(rsp_bus.hit));
            check_field("read_value", 32'(want.read_value), 32'(rsp_bus.read_value));
            check_field("entries_used", 32'(want.entries_used), 32'(rsp_bus.entries_used));
            check_field("table_full_error", 32'(want.table_full_error),
                        32'(rsp_bus.table_full_error));
         end
      end
   end

   initial begin
      #5ms;
      $display("Timeout: %0d of %0d responses received", rsp_count, ops_accepted);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int roll;
      int pool_base;
      int pool_size;
      int fill_len;
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_INSERT;
      req_bus.key = '0;
      req_bus.new_value = '0;
      rsp_bus.ready = 1'b0;

      // directed: empty table, extremes, update in place, shift on delete, spare kinds
      queue_op(KIND_LOOKUP,   8'h00, 16'sh0000);
      queue_op(KIND_DELETE,   8'h00, 16'sh1111);
      queue_op(KIND_REASSIGN, 8'h00, 16'sh2222);
      queue_op(KIND_INSERT,   8'h00, 16'sh8000);
      queue_op(KIND_INSERT,   8'hFF, 16'sh7FFF);
      queue_op(KIND_INSERT,   8'h55, 16'sh5555);
      queue_op(KIND_INSERT,   8'hAA, 16'shAAAA);
      queue_op(KIND_LOOKUP,   8'h00, 16'sh0000);
      queue_op(KIND_LOOKUP,   8'hFF, 16'shFFFF);
      queue_op(KIND_INSERT,   8'h00, 16'sh1234);
      queue_op(KIND_REASSIGN, 8'hFF, 16'shFFFF);
      queue_op(KIND_LOOKUP,   8'hFF, 16'sh0000);
      queue_op(KIND_REASSIGN, 8'h12, 16'sh7777);
      queue_op(KIND_DELETE,   8'h55, 16'sh0000);
      queue_op(KIND_LOOKUP,   8'hAA, 16'sh0000);
      queue_op(KIND_DELETE,   8'h77, 16'sh0000);
      queue_op(KIND_SPARE_A,  8'hAA, 16'sh0F0F);
      queue_op(KIND_SPARE_B,  8'h01, 16'shF0F0);
      queue_op(KIND_SPARE_C,  8'hFF, 16'shFFFF);
      queue_op(KIND_LOOKUP,   8'h55, 16'sh0000);
      queue_op(KIND_CLEAR,    8'hAA, 16'sh0000);
      queue_op(KIND_LOOKUP,   8'hAA, 16'sh0000);
      queue_op(KIND_CLEAR,    8'h00, 16'sh0000);
      queue_op(KIND_DELETE,   8'h00, 16'sh0000);

      while (pending_ops.size() < ITEM_TARGET) begin
         roll = $urandom_range(0, 99);
         pool_base = $urandom_range(0, 255);
         if (roll < 25) begin
            // fill past capacity with distinct keys, then poke at the full table
            fill_len = TABLE_DEPTH + $urandom_range(1, 8);
            queue_op(KIND_CLEAR, KEY_W'($urandom), VALUE_W'($urandom));
            for (int i = 0; i < fill_len; i++)
               queue_op(KIND_INSERT, KEY_W'(pool_base + i), VALUE_W'($urandom));
            repeat ($urandom_range(4, 16))
               queue_op(3'($urandom_range(KIND_INSERT, KIND_LOOKUP)),
                        KEY_W'(pool_base + $urandom_range(0, fill_len + 3)),
                        VALUE_W'($urandom));
         end else if (roll < 85) begin
            pool_size = 1 << $urandom_range(1, 8);
            repeat ($urandom_range(20, 60))
               queue_op(pick_churn_kind(),
                        KEY_W'(pool_base + $urandom_range(0, pool_size - 1)),
                        VALUE_W'($urandom));
         end else begin
            repeat ($urandom_range(4, 12))
               queue_op(3'($urandom_range(KIND_INSERT, KIND_SPARE_C)), KEY_W'($urandom),
                        VALUE_W'($urandom));
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0) @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (expected_q.size() != 0) begin
         $error("%0d expected responses never arrived", expected_q.size());
         mismatches++;
      end
      $display("Checked %0d responses to %0d table operations; %0d lookup hits, %0d deletes.",
               rsp_count, ops_accepted, lookup_hits, delete_hits);
      $display("Table reached %0d of %0d entries; %0d inserts dropped on a full table.",
               peak_count, TABLE_DEPTH, full_drops);
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/kvte_pkg.sv
hw/rtl/kvte_if.sv
hw/rtl/kvte_store.sv
hw/rtl/key_value_table_engine_core.sv
dv/key_value_table_engine_core_tb.sv
